// ===== hdl/rgis_pkg.sv =====
// Package for the readiness-gated install supervisor.
// Holds the phase codes, register indexes, item and result types and defaults.
// No dependencies.
`default_nettype none

package rgis_pkg;

	localparam int unsigned TIME_WIDTH_DEF    = 64;
	localparam int unsigned ATTEMPT_WIDTH_DEF = 32;

	localparam int unsigned IN_TDATA_W  = 72;
	localparam int unsigned OUT_TDATA_W = 48;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam logic [7:0]  RUN_NEEDED_RST  = 8'd3;
	localparam logic [31:0] RETRY_DELAY_RST = 32'd1000000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RUN_NEEDED  = 2'd0,
		REG_RETRY_DELAY = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_WAIT_RUNTIME = 3'd0,
		PH_STABILISING  = 3'd1,
		PH_INSTALLING   = 3'd2,
		PH_WAIT_RETRY   = 3'd3,
		PH_READY        = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0]  run_needed;
		logic [31:0] retry_delay;
	} cfg_t;

	typedef struct packed {
		logic        alive_after_install;
		logic        install_ok;
		logic        worker_alive;
		logic        runtime_up;
		logic [63:0] now_time;
	} item_t;

	typedef struct packed {
		logic        is_ready;
		logic [31:0] attempts;
		logic [7:0]  ready_run;
		phase_t      phase;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/rgis_core.sv =====
// Supervisor state and next-state logic: one tick is applied per accepted item.
// Depends on rgis_pkg.
`default_nettype none

module rgis_core #(
	parameter int unsigned TIME_WIDTH    = rgis_pkg::TIME_WIDTH_DEF,
	parameter int unsigned ATTEMPT_WIDTH = rgis_pkg::ATTEMPT_WIDTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire rgis_pkg::item_t item,
	input  wire rgis_pkg::cfg_t  cfg,
	output rgis_pkg::result_t    result
);
	import rgis_pkg::*;

	localparam int unsigned SUM_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
	localparam logic [ATTEMPT_WIDTH-1:0] ATTEMPT_MAX = {ATTEMPT_WIDTH{1'b1}};

	phase_t                   phase_q, phase_d;
	logic [7:0]               run_q, run_d;
	logic [ATTEMPT_WIDTH-1:0] attempt_q, attempt_d;
	logic [TIME_WIDTH-1:0]    deadline_q, deadline_d;

	logic [TIME_WIDTH-1:0] now_t;
	logic [SUM_W-1:0]      deadline_sum;
	logic [7:0]            need;
	logic [7:0]            run_inc;
	logic                  go_retry;

	assign now_t        = item.now_time[TIME_WIDTH-1:0];
	assign deadline_sum = SUM_W'(now_t) + SUM_W'(cfg.retry_delay);
	assign need         = (cfg.run_needed == 8'd0) ? 8'd1 : cfg.run_needed;
	assign run_inc      = (run_q != 8'hFF) ? run_q + 8'd1 : run_q;

	always_comb begin
		phase_d    = phase_q;
		run_d      = run_q;
		attempt_d  = attempt_q;
		deadline_d = deadline_q;
		go_retry   = 1'b0;
		if (phase_q == PH_READY) begin
			go_retry = !item.worker_alive;
		end else if (phase_q == PH_WAIT_RETRY && now_t < deadline_q) begin
			// hold until the retry deadline has passed
		end else if (!item.runtime_up) begin
			phase_d = PH_WAIT_RUNTIME;
			run_d   = 8'd0;
		end else begin
			phase_d = PH_STABILISING;
			run_d   = run_inc;
			if (run_inc >= need) begin
				if (item.worker_alive) begin
					phase_d = PH_READY;
				end else begin
					// one install attempt, resolved within the tick
					if (attempt_q != ATTEMPT_MAX)
						attempt_d = attempt_q + ATTEMPT_WIDTH'(1);
					if (!item.install_ok || !item.alive_after_install) begin
						go_retry = 1'b1;
					end else begin
						phase_d = PH_READY;
						run_d   = need;
					end
				end
			end
		end
		if (go_retry) begin
			phase_d    = PH_WAIT_RETRY;
			run_d      = 8'd0;
			deadline_d = deadline_sum[TIME_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT_RUNTIME;
			run_q      <= 8'd0;
			attempt_q  <= '0;
			deadline_q <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			run_q      <= run_d;
			attempt_q  <= attempt_d;
			deadline_q <= deadline_d;
		end
	end

	assign result.phase     = phase_d;
	assign result.ready_run = run_d;
	assign result.attempts  = 32'(attempt_d);
	assign result.is_ready  = (phase_d == PH_READY);

endmodule

`default_nettype wire

// ===== hdl/readiness_gated_install_supervisor.sv =====
// Readiness-gated install supervisor.
//
// Slave stream s_*: one item is one tick carrying the time and the backend's
// answers. Master stream m_*: one result item per input item, in order,
// carrying phase, ready run, attempt count and ready flag.
// Configuration: cfg_we/cfg_index/cfg_wdata write the run length (index 0)
// and the retry delay (index 1); write only while no item is in flight.
//
// An accepted item is registered in the input register; the tick is then
// applied and the result registered in the result register, which raises
// m_tvalid. One item per cycle is sustained while m_tready is high: the
// supervisor state updates as the item moves into the result register.
// When m_tready is low the result register holds, then the input register
// fills and s_tready drops; nothing is lost.
// Reset clears both stages and returns the supervisor to waiting for the
// runtime with zero run and attempt counts; the run length resets to 3 and
// the retry delay to 1000000 us.
// Depends on rgis_pkg and rgis_core.
`default_nettype none

module readiness_gated_install_supervisor #(
	parameter int unsigned TIME_WIDTH    = rgis_pkg::TIME_WIDTH_DEF,
	parameter int unsigned ATTEMPT_WIDTH = rgis_pkg::ATTEMPT_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// [63:0] now_time, [64] runtime_up, [65] worker_alive, [66] install_ok,
	// [67] alive_after_install, [71:68] zero
	input  wire logic [rgis_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// [2:0] phase, [10:3] ready_run, [42:11] attempts, [43] is_ready,
	// [47:44] zero
	output logic [rgis_pkg::OUT_TDATA_W-1:0]         m_tdata,
	input  wire logic                                cfg_we,
	input  wire logic [rgis_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rgis_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import rgis_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	result_t res_next;
	logic    valid_s2;
	logic    adv_s1;

	assign adv_s1   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_needed  <= RUN_NEEDED_RST;
			cfg_q.retry_delay <= RETRY_DELAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RUN_NEEDED:  cfg_q.run_needed  <= cfg_wdata[7:0];
				REG_RETRY_DELAY: cfg_q.retry_delay <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (!valid_s2 || m_tready)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			item_s1 <= item_t'(s_tdata[67:0]);
		if (adv_s1)
			res_s2 <= res_next;
	end

	rgis_core #(
		.TIME_WIDTH    (TIME_WIDTH),
		.ATTEMPT_WIDTH (ATTEMPT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_next)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2};

endmodule

`default_nettype wire
